// ===== hdl/iebm_pkg.sv =====
`default_nettype none

package iebm_pkg;

	localparam int ADDR_WIDTH = 8;
	localparam int ADDR_BYTES = (ADDR_WIDTH > 8) ? 2 : 1;

	localparam int DSEL_W     = 7;
	localparam int PHASE_W    = 16;
	localparam int BYTE_W     = 8;
	localparam int STEP_W     = 5;
	localparam int STAGE_W    = 5;
	localparam int BIT_W      = 4;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_DEVICE_SELECT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_TICKS   = 1'b1;

	localparam logic [DSEL_W-1:0]  DSEL_RESET  = 7'd80;
	localparam logic [PHASE_W-1:0] PHASE_RESET = 16'd50;

	localparam logic [BIT_W-1:0] BITS_PER_BYTE = 4'd8;

	localparam logic [STEP_W-1:0] STEP_IDLE   = 5'd0;
	localparam logic [STEP_W-1:0] STEP_ST_A   = 5'd1;
	localparam logic [STEP_W-1:0] STEP_ST_B   = 5'd2;
	localparam logic [STEP_W-1:0] STEP_ST_C   = 5'd3;
	localparam logic [STEP_W-1:0] STEP_ST_D   = 5'd4;
	localparam logic [STEP_W-1:0] STEP_WB_SET = 5'd5;
	localparam logic [STEP_W-1:0] STEP_WB_HI  = 5'd6;
	localparam logic [STEP_W-1:0] STEP_WB_LO  = 5'd7;
	localparam logic [STEP_W-1:0] STEP_ACK_HI = 5'd8;
	localparam logic [STEP_W-1:0] STEP_ACK_LO = 5'd9;
	localparam logic [STEP_W-1:0] STEP_RB_HI  = 5'd10;
	localparam logic [STEP_W-1:0] STEP_RB_LO  = 5'd11;
	localparam logic [STEP_W-1:0] STEP_NK_SET = 5'd12;
	localparam logic [STEP_W-1:0] STEP_NK_HI  = 5'd13;
	localparam logic [STEP_W-1:0] STEP_NK_LO  = 5'd14;
	localparam logic [STEP_W-1:0] STEP_SP_A   = 5'd15;
	localparam logic [STEP_W-1:0] STEP_SP_B   = 5'd16;
	localparam logic [STEP_W-1:0] STEP_SP_C   = 5'd17;

	localparam logic [STAGE_W-1:0] STG_START      = 5'd0;
	localparam logic [STAGE_W-1:0] STG_SEL_WR     = 5'd1;
	localparam logic [STAGE_W-1:0] STG_ADDR_LAST  = STAGE_W'(1 + ADDR_BYTES);
	localparam logic [STAGE_W-1:0] STG_AFTER_ADDR = STAGE_W'(2 + ADDR_BYTES);
	localparam logic [STAGE_W-1:0] STG_SEL_RD     = STAGE_W'(3 + ADDR_BYTES);
	localparam logic [STAGE_W-1:0] STG_READ       = STAGE_W'(4 + ADDR_BYTES);

	typedef struct packed {
		logic              req_valid;
		logic              req_type;
		logic [BYTE_W-1:0] mem_address;
		logic [BYTE_W-1:0] write_data;
		logic              sda_in;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

	typedef struct packed {
		logic scl;
		logic sda;
		logic drv;
	} bus_t;

	typedef struct packed {
		logic [STAGE_W-1:0] stage;
		logic [STEP_W-1:0]  step;
		logic [BYTE_W-1:0]  shift;
	} ent_t;

	function automatic bus_t bus_of(input logic [STEP_W-1:0] st, input logic msb);
		bus_t b;
		unique case (st) inside
			STEP_IDLE, STEP_ST_B:                    b = '{1'b1, 1'b1, 1'b1};
			STEP_ST_A:                               b = '{1'b0, 1'b1, 1'b1};
			STEP_ST_C:                               b = '{1'b1, 1'b0, 1'b1};
			STEP_ST_D, STEP_SP_A:                    b = '{1'b0, 1'b0, 1'b1};
			STEP_WB_SET, STEP_WB_LO:                 b = '{1'b0, msb, 1'b1};
			STEP_WB_HI:                              b = '{1'b1, msb, 1'b1};
			STEP_ACK_HI, STEP_RB_HI:                 b = '{1'b1, 1'b1, 1'b0};
			STEP_ACK_LO, STEP_RB_LO:                 b = '{1'b0, 1'b1, 1'b0};
			STEP_NK_SET, STEP_NK_LO:                 b = '{1'b0, 1'b1, 1'b1};
			STEP_NK_HI, STEP_SP_C:                   b = '{1'b1, 1'b1, 1'b1};
			STEP_SP_B:                               b = '{1'b1, 1'b0, 1'b1};
			default:                                 b = '{1'b1, 1'b1, 1'b1};
		endcase
		return b;
	endfunction

	function automatic ent_t enter_stage(
		input logic [STAGE_W-1:0] s,
		input logic               ltype,
		input logic [BYTE_W-1:0]  laddr,
		input logic [BYTE_W-1:0]  ldata,
		input logic [BYTE_W-1:0]  shift,
		input logic [DSEL_W-1:0]  dsel
	);
		ent_t              e;
		logic [BYTE_W-1:0] sel;
		sel     = {dsel, 1'b0};
		e.stage = s;
		e.step  = STEP_SP_A;
		e.shift = shift;
		if (s == STG_START) begin
			e.step = STEP_ST_A;
		end else if (s == STG_SEL_WR) begin
			e.shift = sel;
			e.step  = STEP_WB_SET;
		end else if (s <= STG_ADDR_LAST) begin
			e.shift = (s == STG_ADDR_LAST) ? laddr : '0;
			e.step  = STEP_WB_SET;
		end else if (ltype) begin
			if (s == STG_AFTER_ADDR) begin
				e.shift = ldata;
				e.step  = STEP_WB_SET;
			end
		end else if (s == STG_AFTER_ADDR) begin
			e.step = STEP_ST_A;
		end else if (s == STG_SEL_RD) begin
			e.shift = sel | 8'h01;
			e.step  = STEP_WB_SET;
		end else if (s == STG_READ) begin
			e.shift = '0;
			e.step  = STEP_RB_HI;
		end
		return e;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/iebm_front.sv =====
`default_nettype none

module iebm_front
	import iebm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              req_valid,
	input  wire logic              req_type,
	input  wire logic [BYTE_W-1:0] mem_address,
	input  wire logic [BYTE_W-1:0] write_data,
	input  wire logic              sda_in,
	input  wire logic              pop,
	output head_t                  head
);

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	item_t             item;

	assign in_stall = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign push     = in_valid && !in_stall;

	always_comb begin
		item.req_valid   = req_valid;
		item.req_type    = req_type;
		item.mem_address = mem_address;
		item.write_data  = write_data;
		item.sda_in      = sda_in;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head.valid = (count_q != '0);
	assign head.item  = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

// ===== hdl/iebm_back.sv =====
`default_nettype none

module iebm_back
	import iebm_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire head_t              head,
	output logic                    pop,
	input  wire logic [DSEL_W-1:0]  dsel,
	input  wire logic [PHASE_W-1:0] phase_ticks,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    scl_level,
	output logic                    sda_out,
	output logic                    sda_drive,
	output logic                    busy_res,
	output logic                    done_res,
	output logic [BYTE_W-1:0]       read_data
);

	logic [STEP_W-1:0]  step_q,  step_n;
	logic [BIT_W-1:0]   bit_q,   bit_n;
	logic [BYTE_W-1:0]  shift_q, shift_n;
	logic [PHASE_W-1:0] timer_q, timer_n;
	logic [STAGE_W-1:0] stage_q, stage_n;
	logic               ltype_q, ltype_n;
	logic [BYTE_W-1:0]  laddr_q, laddr_n;
	logic [BYTE_W-1:0]  ldata_q, ldata_n;
	logic [BYTE_W-1:0]  rx_q,    rx_n;

	logic               out_valid_q;
	logic               scl_q, sda_q, drv_q, busy_q, done_q;
	logic [BYTE_W-1:0]  read_data_q;

	logic [STEP_W-1:0]  st;
	logic [PHASE_W-1:0] len;
	logic               busy;
	logic               done;
	bus_t               bus;
	ent_t               ent;

	assign pop = head.valid && (!out_valid_q || !out_stall);
	assign len = (phase_ticks == '0) ? PHASE_W'(1) : phase_ticks;

	always_comb begin
		step_n  = step_q;
		bit_n   = bit_q;
		shift_n = shift_q;
		timer_n = timer_q;
		stage_n = stage_q;
		ltype_n = ltype_q;
		laddr_n = laddr_q;
		ldata_n = ldata_q;
		rx_n    = rx_q;
		done    = 1'b0;
		ent     = '0;

		if (step_q == STEP_IDLE && head.item.req_valid) begin
			ltype_n = head.item.req_type;
			laddr_n = head.item.mem_address;
			ldata_n = head.item.write_data;
			ent     = enter_stage(STG_START, ltype_n, laddr_n, ldata_n, shift_n, dsel);
			stage_n = ent.stage;
			step_n  = ent.step;
			shift_n = ent.shift;
			bit_n   = '0;
			timer_n = '0;
		end

		st   = step_n;
		bus  = bus_of(st, shift_n[BYTE_W-1]);
		busy = (st != STEP_IDLE);

		if (busy) begin
			if ({1'b0, timer_n} + (PHASE_W+1)'(1) < {1'b0, len}) begin
				timer_n = timer_n + 1'b1;
			end else begin
				timer_n = '0;
				unique case (st) inside
					STEP_ST_D, STEP_ACK_LO, STEP_NK_LO: begin
						ent     = enter_stage(stage_n + 1'b1, ltype_n, laddr_n, ldata_n,
							shift_n, dsel);
						stage_n = ent.stage;
						step_n  = ent.step;
						shift_n = ent.shift;
						bit_n   = '0;
					end
					STEP_WB_LO: begin
						bit_n   = bit_n + 1'b1;
						shift_n = {shift_n[BYTE_W-2:0], 1'b0};
						step_n  = (bit_n >= BITS_PER_BYTE) ? STEP_ACK_HI : STEP_WB_SET;
					end
					STEP_RB_HI: begin
						shift_n = {shift_n[BYTE_W-2:0], head.item.sda_in};
						step_n  = STEP_RB_LO;
					end
					STEP_RB_LO: begin
						bit_n = bit_n + 1'b1;
						if (bit_n >= BITS_PER_BYTE) begin
							rx_n   = shift_n;
							step_n = STEP_NK_SET;
						end else begin
							step_n = STEP_RB_HI;
						end
					end
					STEP_SP_C: begin
						step_n = STEP_IDLE;
						bit_n  = '0;
						done   = 1'b1;
					end
					default: begin
						step_n = st + 1'b1;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_IDLE;
			bit_q       <= '0;
			shift_q     <= '0;
			timer_q     <= '0;
			stage_q     <= STG_START;
			ltype_q     <= 1'b0;
			laddr_q     <= '0;
			ldata_q     <= '0;
			rx_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				step_q  <= step_n;
				bit_q   <= bit_n;
				shift_q <= shift_n;
				timer_q <= timer_n;
				stage_q <= stage_n;
				ltype_q <= ltype_n;
				laddr_q <= laddr_n;
				ldata_q <= ldata_n;
				rx_q    <= rx_n;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			scl_q       <= bus.scl;
			sda_q       <= bus.sda;
			drv_q       <= bus.drv;
			busy_q      <= busy;
			done_q      <= done;
			read_data_q <= rx_n;
		end
	end

	assign out_valid = out_valid_q;
	assign scl_level = scl_q;
	assign sda_out   = sda_q;
	assign sda_drive = drv_q;
	assign busy_res  = busy_q;
	assign done_res  = done_q;
	assign read_data = read_data_q;

endmodule

`default_nettype wire

// ===== hdl/i2c_eeprom_byte_master_unit.sv =====
`default_nettype none

// Two-wire EEPROM master (random read, byte write) stepped by bus ticks: every
// accepted input transaction is one tick and yields exactly one output transaction
// carrying the clock and data line levels, busy, a one-tick done pulse and the
// last byte read. A two-entry input queue feeds a sequencer that retires one tick
// per clock into an output register while the output does not stall, so the block
// then sustains one transaction per cycle; an accepted input transaction is written
// into the queue and, once popped, into the output register. While the output stalls
// the queue fills up to its two entries, then the input stalls. Each bus phase
// lasts phase_ticks ticks (zero acts as one); the user must write device_select and
// phase_ticks only while no transaction is in flight, as the block does not enforce it.
module i2c_eeprom_byte_master_unit
	import iebm_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  req_valid,
	input  wire logic                  req_type,
	input  wire logic [BYTE_W-1:0]     mem_address,
	input  wire logic [BYTE_W-1:0]     write_data,
	input  wire logic                  sda_in,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       scl_level,
	output logic                       sda_out,
	output logic                       sda_drive,
	output logic                       busy_res,
	output logic                       done_res,
	output logic [BYTE_W-1:0]          read_data
);

	logic [DSEL_W-1:0]  dsel_q;
	logic [PHASE_W-1:0] phase_q;
	head_t              head;
	logic               pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dsel_q  <= DSEL_RESET;
			phase_q <= PHASE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEVICE_SELECT: dsel_q  <= cfg_data[DSEL_W-1:0];
				REG_PHASE_TICKS:   phase_q <= cfg_data[PHASE_W-1:0];
			endcase
		end
	end

	iebm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_valid   (req_valid),
		.req_type    (req_type),
		.mem_address (mem_address),
		.write_data  (write_data),
		.sda_in      (sda_in),
		.pop         (pop),
		.head        (head)
	);

	iebm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.pop         (pop),
		.dsel        (dsel_q),
		.phase_ticks (phase_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.scl_level   (scl_level),
		.sda_out     (sda_out),
		.sda_drive   (sda_drive),
		.busy_res    (busy_res),
		.done_res    (done_res),
		.read_data   (read_data)
	);

	a_full_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> head.valid)
		else $error("queue full without a head entry");

	a_out_from_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(pop))
		else $error("output transaction without a popped tick");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && done_res) |-> busy_res)
		else $error("done pulse outside a transfer");

endmodule

`default_nettype wire
